### hdl/ucmd_pkg.sv
// Package for the text command interpreter: item types, command descriptor,
// reply text tables and register codes. No dependencies.
package ucmd_pkg;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [15:0] temperature_tenths;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       write_valid;
        logic [2:0] write_index;
        logic [7:0] write_value;
        logic       last_byte;
    } t_out_item;

    typedef enum logic [2:0] {
        K_LED_OFF,
        K_LED_ON,
        K_TEMP,
        K_SERVO,
        K_STEPPER,
        K_UNKNOWN
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic [15:0] temp;
    } t_cmd;

    typedef enum logic [1:0] {
        NP_BLANK,
        NP_SIGN,
        NP_DIGITS,
        NP_DONE
    } t_nphase;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_CONV,
        B_PRE,
        B_NUM,
        B_MID,
        B_SUF
    } t_bstate;

    localparam int QDEPTH = 4;
    localparam int QPW    = 2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [2:0] REG_LED     = 3'd4;
    localparam logic [2:0] REG_SERVO   = 3'd5;
    localparam logic [2:0] REG_STEPPER = 3'd6;

    localparam logic [7:0]  STEP_RESET = 8'd208;
    localparam logic [15:0] RECIP10    = 16'hCCCD;

    localparam logic [127:0] S_LED_OFF = {"LED_OFF", "_OK\015\012"};
    localparam logic [127:0] S_LED_ON  = {"LED_ON", "_OK\015\012"};
    localparam logic [127:0] S_UNKNOWN = "UNKNOWN\015\012";
    localparam logic [127:0] S_TEMP    = "TEMP:";
    localparam logic [127:0] S_SERVO   = "servo:";
    localparam logic [127:0] S_STEPPER = "stepper:";
    localparam logic [127:0] S_SUF_T   = " C\015\012";
    localparam logic [127:0] S_SUF     = "\015\012";

    function automatic logic [7:0] str_ch(logic [127:0] s, logic [3:0] len,
                                          logic [3:0] idx);
        logic [3:0] k;
        k = len - 4'd1 - idx;
        return s[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] pre_len(t_kind kind);
        logic [3:0] n;
        unique case (kind)
            K_LED_OFF: n = 4'd12;
            K_LED_ON:  n = 4'd11;
            K_TEMP:    n = 4'd5;
            K_SERVO:   n = 4'd6;
            K_STEPPER: n = 4'd8;
            default:   n = 4'd9;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pre_char(t_kind kind, logic [3:0] idx);
        logic [127:0] s;
        unique case (kind)
            K_LED_OFF: s = S_LED_OFF;
            K_LED_ON:  s = S_LED_ON;
            K_TEMP:    s = S_TEMP;
            K_SERVO:   s = S_SERVO;
            K_STEPPER: s = S_STEPPER;
            default:   s = S_UNKNOWN;
        endcase
        return str_ch(s, pre_len(kind), idx);
    endfunction

endpackage

### hdl/uart_text_command_interpreter.sv
// Top level of the text command interpreter: front end, command queue and
// reply generator. Depends on ucmd_pkg, ucmd_front, ucmd_fifo, ucmd_back.
//
//  channel | direction | handshake                | payload
//  input   | in        | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_ready| o_out_data (t_out_item)
//
// One received byte is taken per cycle; o_in_ready drops only while the
// four-entry command queue is full. A reply starts with a pop, then digit
// conversion (one divide-by-ten per cycle), then the reply bytes stream out.
// Synchronous active-low reset clears all line and queue state.
// A stalled output holds its register; the front keeps taking bytes meanwhile.
module uart_text_command_interpreter import ucmd_pkg::*; #(
    parameter int LINE_CHARS = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic push, pop, full, empty;
    t_cmd cmd_in, cmd_out;

    assign o_in_ready = !full;

    ucmd_front #(.LINE_CHARS(LINE_CHARS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (i_in_valid && o_in_ready),
        .i_item  (i_in_data),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    ucmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_full  (full),
        .o_empty (empty)
    );

    ucmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### hdl/ucmd_front.sv
// Front end, uses ucmd_pkg: tracks keywords, colon and operand per received line.
// Emits one command descriptor per non-empty line, bar colonless servo/stepper.
module ucmd_front import ucmd_pkg::*; #(
    parameter int LINE_CHARS = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_acc,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam int CW = $clog2(LINE_CHARS);
    localparam logic [CW-1:0] MAXC = CW'(LINE_CHARS - 1);

    logic [63:0]   r_recent, n_recent;
    logic [CW-1:0] r_count, n_count;
    logic          r_cut, n_cut;
    logic [4:0]    r_hits, n_hits;
    logic          r_colon, n_colon;
    t_nphase       r_phase, n_phase;
    logic [7:0]    r_numv, n_numv;
    logic          r_neg, n_neg;
    logic [7:0]    r_step, n_step;
    logic          r_stake, n_stake;

    logic [7:0] c;
    logic [7:0] dval;
    logic       digit;
    logic       blank;
    logic [7:0] times10;
    t_kind      kind;

    assign c       = i_item.rx_byte;
    assign dval    = c - CH_ZERO;
    assign digit   = (c >= CH_ZERO) && (c <= 8'h39);
    assign blank   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    assign times10 = {r_numv[4:0], 3'b000} + {r_numv[6:0], 1'b0};

    always_comb begin
        if (r_hits[0]) begin
            kind = K_LED_OFF;
        end else if (r_hits[1]) begin
            kind = K_LED_ON;
        end else if (r_hits[2]) begin
            kind = K_TEMP;
        end else if (r_hits[3]) begin
            kind = K_SERVO;
        end else if (r_hits[4]) begin
            kind = K_STEPPER;
        end else begin
            kind = K_UNKNOWN;
        end
    end

    always_comb begin
        n_recent = r_recent;
        n_count  = r_count;
        n_cut    = r_cut;
        n_hits   = r_hits;
        n_colon  = r_colon;
        n_phase  = r_phase;
        n_numv   = r_numv;
        n_neg    = r_neg;
        n_step   = r_step;
        n_stake  = r_stake;
        o_push   = 1'b0;
        o_cmd.kind  = kind;
        o_cmd.temp  = i_item.temperature_tenths;
        o_cmd.value = (kind == K_SERVO) ? (r_neg ? 8'd0 - r_numv : r_numv) : r_step;
        if (i_acc) begin
            if (c == CH_LF) begin
                if (r_count != '0) begin
                    o_push   = !(((kind == K_SERVO) || (kind == K_STEPPER)) && !r_colon);
                    n_recent = '0;
                    n_count  = '0;
                    n_cut    = 1'b0;
                    n_hits   = '0;
                    n_colon  = 1'b0;
                    n_phase  = NP_BLANK;
                    n_numv   = '0;
                    n_neg    = 1'b0;
                    n_step   = STEP_RESET;
                    n_stake  = 1'b0;
                end
            end else if ((c != CH_CR) && (r_count < MAXC)) begin
                n_count = r_count + CW'(1);
                if (!r_cut) begin
                    if (c == CH_NUL) begin
                        n_cut = 1'b1;
                    end else begin
                        n_recent = {r_recent[55:0], c};
                        if (n_recent[55:0] == "LED_OFF")  n_hits[0] = 1'b1;
                        if (n_recent[47:0] == "LED_ON")   n_hits[1] = 1'b1;
                        if (n_recent[63:0] == {"GET_", "TEMP"}) n_hits[2] = 1'b1;
                        if (n_recent[39:0] == "servo")    n_hits[3] = 1'b1;
                        if (n_recent[55:0] == "stepper")  n_hits[4] = 1'b1;
                        if (!r_colon) begin
                            n_colon = (c == CH_COLON);
                        end else begin
                            if (!r_stake) begin
                                n_step  = dval;
                                n_stake = 1'b1;
                            end
                            case (r_phase)
                                NP_BLANK: begin
                                    if (blank) begin
                                        n_phase = NP_BLANK;
                                    end else if (c == CH_PLUS) begin
                                        n_phase = NP_SIGN;
                                    end else if (c == CH_MINUS) begin
                                        n_neg   = 1'b1;
                                        n_phase = NP_SIGN;
                                    end else if (digit) begin
                                        n_numv  = dval;
                                        n_phase = NP_DIGITS;
                                    end else begin
                                        n_phase = NP_DONE;
                                    end
                                end
                                NP_SIGN: begin
                                    if (digit) begin
                                        n_numv  = dval;
                                        n_phase = NP_DIGITS;
                                    end else begin
                                        n_phase = NP_DONE;
                                    end
                                end
                                NP_DIGITS: begin
                                    if (digit) begin
                                        n_numv = times10 + dval;
                                    end else begin
                                        n_phase = NP_DONE;
                                    end
                                end
                                default: n_phase = r_phase;
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_count  <= '0;
            r_cut    <= 1'b0;
            r_hits   <= '0;
            r_colon  <= 1'b0;
            r_phase  <= NP_BLANK;
            r_numv   <= '0;
            r_neg    <= 1'b0;
            r_step   <= STEP_RESET;
            r_stake  <= 1'b0;
        end else begin
            r_recent <= n_recent;
            r_count  <= n_count;
            r_cut    <= n_cut;
            r_hits   <= n_hits;
            r_colon  <= n_colon;
            r_phase  <= n_phase;
            r_numv   <= n_numv;
            r_neg    <= n_neg;
            r_step   <= n_step;
            r_stake  <= n_stake;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC) else $error("line count past limit");

    a_push_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_acc && (c == CH_LF) && (r_count != '0)))
        else $error("command pushed outside line end");

endmodule

### hdl/ucmd_fifo.sv
// Short command queue between front end and reply generator.
// Depends on ucmd_pkg.
module ucmd_fifo import ucmd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd           r_mem [QDEPTH];
    logic [QPW-1:0] r_wp, r_rp;
    logic [QPW:0]   r_cnt;

    assign o_full  = (r_cnt == (QPW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QPW'(1);
            if (i_pop)  r_rp <= r_rp + QPW'(1);
            r_cnt <= r_cnt + (QPW+1)'(i_push) - (QPW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");

endmodule

### hdl/ucmd_back.sv
// Reply generator: pops commands, converts numbers to decimal digits one per
// cycle, and streams reply bytes through an output register. Depends on ucmd_pkg.
module ucmd_back import ucmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_bstate    r_state, n_state;
    t_cmd       r_cmd;
    logic [3:0] r_pos;
    logic [15:0] r_num;
    logic [3:0] r_frac;
    logic [3:0] r_dig [4];
    logic [2:0] r_nd;
    logic       r_first;
    logic       r_ov;
    t_out_item  r_out;

    logic        can_load;
    logic        emit;
    logic [7:0]  e_byte;
    logic        e_last;
    logic        seg_end;
    logic        has_num;
    logic [3:0]  suf_len;
    logic [15:0] mul_in;
    logic [31:0] prod;
    logic [12:0] quo;
    logic [15:0] rem;
    logic        wv;
    logic [2:0]  widx;
    logic [7:0]  wval;

    assign can_load = !r_ov || i_out_ready;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign has_num  = (r_cmd.kind == K_TEMP) || (r_cmd.kind == K_SERVO)
                      || (r_cmd.kind == K_STEPPER);
    assign suf_len  = (r_cmd.kind == K_TEMP) ? 4'd4 : 4'd2;
    assign mul_in   = (r_state == B_DIV) ? r_cmd.temp : r_num;
    assign prod     = 32'(mul_in) * 32'(RECIP10);
    assign quo      = prod[31:19];
    assign rem      = mul_in - ({3'b000, quo} * 16'd10);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        K_TEMP:             n_state = B_DIV;
                        K_SERVO, K_STEPPER: n_state = B_CONV;
                        default:            n_state = B_PRE;
                    endcase
                end
            end
            B_DIV:  n_state = B_CONV;
            B_CONV: if (quo == '0) n_state = B_PRE;
            B_PRE:  if (emit && seg_end) n_state = has_num ? B_NUM : B_IDLE;
            B_NUM:  if (emit && seg_end) n_state = (r_cmd.kind == K_TEMP) ? B_MID : B_SUF;
            B_MID:  if (emit && seg_end) n_state = B_SUF;
            B_SUF:  if (emit && seg_end) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        e_byte  = '0;
        seg_end = 1'b0;
        emit    = 1'b0;
        e_last  = 1'b0;
        unique case (r_state)
            B_PRE: begin
                emit    = can_load;
                e_byte  = pre_char(r_cmd.kind, r_pos);
                seg_end = (r_pos == pre_len(r_cmd.kind) - 4'd1);
                e_last  = seg_end && !has_num;
            end
            B_NUM: begin
                emit    = can_load;
                e_byte  = CH_ZERO + {4'b0000, r_dig[2'(r_nd - 3'd1)]};
                seg_end = (r_nd == 3'd1);
            end
            B_MID: begin
                emit    = can_load;
                e_byte  = (r_pos == 4'd0) ? CH_DOT : CH_ZERO + {4'b0000, r_frac};
                seg_end = (r_pos == 4'd1);
            end
            B_SUF: begin
                emit    = can_load;
                e_byte  = (r_cmd.kind == K_TEMP) ? str_ch(S_SUF_T, suf_len, r_pos)
                                                 : str_ch(S_SUF, suf_len, r_pos);
                seg_end = (r_pos == suf_len - 4'd1);
                e_last  = seg_end;
            end
            default: emit = 1'b0;
        endcase
    end

    always_comb begin
        wv   = 1'b1;
        widx = REG_LED;
        wval = r_cmd.value;
        case (r_cmd.kind)
            K_LED_OFF: wval = 8'd0;
            K_LED_ON:  wval = 8'd1;
            K_SERVO:   widx = REG_SERVO;
            K_STEPPER: widx = REG_STEPPER;
            default:   wv = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_num <= {8'd0, i_cmd.value};
            r_pos <= '0;
        end
        if (r_state == B_DIV) begin
            r_frac <= rem[3:0];
            r_num  <= {3'b000, quo};
        end
        if (r_state == B_CONV) begin
            r_dig[r_nd[1:0]] <= rem[3:0];
            r_num <= {3'b000, quo};
        end
        if (emit) begin
            r_pos <= seg_end ? 4'd0 : r_pos + 4'd1;
            r_out.reply_byte  <= e_byte;
            r_out.write_valid <= r_first && wv;
            r_out.write_index <= (r_first && wv) ? widx : 3'd0;
            r_out.write_value <= (r_first && wv) ? wval : 8'd0;
            r_out.last_byte   <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_nd    <= '0;
            r_first <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_nd    <= '0;
                r_first <= 1'b1;
            end else if (r_state == B_CONV) begin
                r_nd <= r_nd + 3'd1;
            end else if (emit && (r_state == B_NUM)) begin
                r_nd <= r_nd - 3'd1;
            end
            if (emit) begin
                r_first <= 1'b0;
                r_ov    <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_widx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.write_valid) |->
        ((o_out_data.write_index == REG_LED) || (o_out_data.write_index == REG_SERVO)
         || (o_out_data.write_index == REG_STEPPER)))
        else $error("bad register index");

    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_NUM) |-> ((r_nd != 3'd0) && (r_nd <= 3'd4)))
        else $error("digit count out of range");

endmodule
